// ===== rtl/core/planar_tile_row_decoder_core_macros.svh =====
// Assertion macros used by the decoder's checker file.
`ifndef PLANAR_TILE_ROW_DECODER_CORE_MACROS_SVH
`define PLANAR_TILE_ROW_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTRD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptrd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptrd assertion failed");

`endif

// ===== rtl/core/ptrd_pkg.sv =====
// Package with widths, types and the pixel interleave function of the tile row decoder.
`default_nettype none
package ptrd_pkg;

  localparam int WORD_W       = 16;
  localparam int PIX_W        = 4;
  localparam int ROW_PIX      = 16;
  localparam int ROW_W        = PIX_W * ROW_PIX;
  localparam int ROW_NUM_W    = 4;
  localparam int POS_W        = 6;
  localparam int SPRITE_LINES = 16;
  localparam int TILE_LINES   = 8;
  localparam int BYTE_W       = 8;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [ROW_NUM_W-1:0] row_num_t;
  typedef logic [POS_W-1:0]     pos_t;

  // Contents of the input register: one accepted word and where it falls.
  typedef struct packed {
    word_t word;
    pos_t  pos;
    logic  tile_mode;
  } stage_t;

  localparam row_num_t SPRITE_LAST = row_num_t'(SPRITE_LINES - 1);
  localparam row_num_t TILE_LAST   = row_num_t'(TILE_LINES - 1);

  // Pixel n (leftmost first) takes bit WORD_W-1-n of each plane; plane 0 is the lsb.
  function automatic row_t interleave(input word_t p0, input word_t p1,
                                      input word_t p2, input word_t p3);
    row_t row;
    row = '0;
    for (int n = 0; n < ROW_PIX; n++) begin
      row[PIX_W*n +: PIX_W] = {p3[WORD_W-1-n], p2[WORD_W-1-n],
                               p1[WORD_W-1-n], p0[WORD_W-1-n]};
    end
    return row;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ptrd_word_if.sv =====
// Channel interfaces: graphics word requests in and decoded row requests out.
`default_nettype none
interface ptrd_word_if;
  import ptrd_pkg::*;
  logic  valid;
  logic  ready;
  word_t graphics_word;
  modport source (output valid, output graphics_word, input ready);
  modport sink   (input valid, input graphics_word, output ready);
endinterface

interface ptrd_row_if;
  import ptrd_pkg::*;
  logic     valid;
  logic     ready;
  row_t     row_pixels;
  row_num_t row_number;
  logic     last_row;
  modport source (output valid, output row_pixels, output row_number, output last_row,
                  input ready);
  modport sink   (input valid, input row_pixels, input row_number, input last_row,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/planar_tile_row_decoder_core.sv =====
// Top level of the planar tile row decoder: bitplane words in, 4-bit pixel rows out.
//
// Usage: graphics words arrive as requests on in_word (valid/ready). In sprite
// mode (cfg 0) a 16x16 sprite is 64 words, plane 0 for lines 0..15 first, then
// planes 1, 2 and 3; every plane-3 word yields one row. In tile mode (cfg 1) an
// 8x8 tile is 16 words; words 0..7 carry planes 0/1 as high/low byte, words
// 8..15 carry planes 2/3 and each yields one row in the low 32 bits of
// row_pixels. Rows leave as requests on out_row with row_number and last_row.
// Path: an accepted word is written to the input register, is decoded there,
// and its row is written into the output register, which drives out_row.
// Throughput: one word per cycle unless a row waits on a stalled receiver, set by
// the single decode stage between the input and output registers.
// A stalled receiver holds its row in the output register; non-emitting words
// keep flowing, and in_word.ready drops only when a row-producing word waits
// behind an occupied output. Writing cfg_wr_data (while the block is idle)
// selects the mode and restarts the word count. Synchronous reset clears the
// word count, the mode and both valid flags; the plane store is not cleared.
`default_nettype none
module planar_tile_row_decoder_core (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data,
  ptrd_word_if.sink  in_word,
  ptrd_row_if.source out_row
);
  import ptrd_pkg::*;

  // Mode register and position of the next word in the sprite or tile.
  logic tile_mode_r;
  pos_t pos_r, pos_nxt;

  // Input register stage.
  logic   s1_valid_r;
  stage_t s1_r;

  // Plane store: planes 0..2 per line, tile mode uses the low byte of planes 0 and 1.
  word_t plane0_r [SPRITE_LINES];
  word_t plane1_r [SPRITE_LINES];
  word_t plane2_r [SPRITE_LINES];

  // Output register.
  logic     out_valid_r;
  row_t     out_pixels_r;
  row_num_t out_number_r;
  logic     out_last_r;

  logic     in_fire;
  logic     s1_emit;
  logic     s1_adv;
  row_num_t s1_line;
  logic     s1_last;
  row_t     s1_row;
  logic [1:0] s1_plane;

  assign in_fire = in_word.valid && in_word.ready;

  // Sprite mode counts 0..63, tile mode 0..15.
  always_comb begin
    if (tile_mode_r) begin
      pos_nxt = {2'b00, pos_r[3:0] + 4'd1};
    end else begin
      pos_nxt = pos_r + pos_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_mode_r <= 1'b0;
      pos_r       <= '0;
    end else if (cfg_wr_en) begin
      tile_mode_r <= cfg_wr_data;
      pos_r       <= '0;
    end else if (in_fire) begin
      pos_r <= pos_nxt;
    end
  end

  // Decode of the word in the input register.
  assign s1_plane = s1_r.pos[5:4];

  always_comb begin
    if (s1_r.tile_mode) begin
      s1_line = {1'b0, s1_r.pos[2:0]};
      s1_emit = s1_r.pos[3];
      s1_last = (s1_line == TILE_LAST);
      // Byte planes sit in the top of the word so that pixels 8..15 come out zero.
      s1_row  = interleave({plane0_r[s1_line][BYTE_W-1:0], BYTE_W'(0)},
                           {plane1_r[s1_line][BYTE_W-1:0], BYTE_W'(0)},
                           {s1_r.word[WORD_W-1:BYTE_W], BYTE_W'(0)},
                           {s1_r.word[BYTE_W-1:0], BYTE_W'(0)});
    end else begin
      s1_line = s1_r.pos[3:0];
      s1_emit = (s1_plane == 2'd3);
      s1_last = (s1_line == SPRITE_LAST);
      s1_row  = interleave(plane0_r[s1_line], plane1_r[s1_line],
                           plane2_r[s1_line], s1_r.word);
    end
  end

  // A storing word always moves on; a row needs room in the output register.
  assign s1_adv        = s1_valid_r && (!s1_emit || !out_valid_r || out_row.ready);
  assign in_word.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_word.ready) begin
      s1_valid_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= '{word: in_word.graphics_word, pos: pos_r, tile_mode: tile_mode_r};
    end
  end

  // Plane store writes, done as the storing word leaves the input register.
  always_ff @(posedge clk) begin
    if (s1_adv && !s1_emit) begin
      if (s1_r.tile_mode) begin
        plane0_r[s1_line] <= {BYTE_W'(0), s1_r.word[WORD_W-1:BYTE_W]};
        plane1_r[s1_line] <= {BYTE_W'(0), s1_r.word[BYTE_W-1:0]};
      end else begin
        unique case (s1_plane)
          2'd0:    plane0_r[s1_line] <= s1_r.word;
          2'd1:    plane1_r[s1_line] <= s1_r.word;
          default: plane2_r[s1_line] <= s1_r.word;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_row.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_pixels_r <= s1_row;
      out_number_r <= s1_line;
      out_last_r   <= s1_last;
    end
  end

  assign out_row.valid      = out_valid_r;
  assign out_row.row_pixels = out_pixels_r;
  assign out_row.row_number = out_number_r;
  assign out_row.last_row   = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/core/ptrd_checker.sv =====
// Port-level checker for the tile row decoder and its bind to the top level.
`default_nettype none
`include "planar_tile_row_decoder_core_macros.svh"
module ptrd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire ptrd_pkg::row_t     out_pixels,
  input wire ptrd_pkg::row_num_t out_number,
  input wire logic               out_last
);
  import ptrd_pkg::*;

  // A stalled row request keeps its contents.
  `PTRD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_pixels) && $stable(out_number) && $stable(out_last))

  // Only line 7 of a tile or line 15 of a sprite closes a block.
  `PTRD_ASSERT_IMPL(a_last_line, clk, rst_n, out_valid && out_last,
    out_number == SPRITE_LAST || out_number == TILE_LAST)

  // A final tile row carries pixels only in its low half.
  `PTRD_ASSERT_IMPL(a_tile_half, clk, rst_n, out_valid && out_last && out_number == TILE_LAST,
    out_pixels[ROW_W-1:ROW_W/2] == '0)

endmodule

bind planar_tile_row_decoder_core ptrd_checker u_ptrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_row.valid),
  .out_ready  (out_row.ready),
  .out_pixels (out_row.row_pixels),
  .out_number (out_row.row_number),
  .out_last   (out_row.last_row)
);
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the planar tile row decoder core, sprite and tile modes.
module tb;
  import ptrd_pkg::*;

  // The one configuration bit selects how the word stream is laid out.
  typedef enum logic {MODE_SPRITE = 1'b0, MODE_TILE = 1'b1} mode_e;

  // A row of the directed table either sends a graphics word or writes the mode.
  typedef enum logic {STEP_WORD = 1'b0, STEP_MODE = 1'b1} step_kind_e;

  typedef struct packed {
    row_t     pixels;
    row_num_t number;
    logic     last;
  } row_expect_t;

  // When typed is set, the row that this word completes is taken from the table
  // instead of from the decoder shadow below.
  typedef struct packed {
    step_kind_e  kind;
    word_t       data;
    logic        typed;
    row_expect_t row;
  } plan_step_t;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 4;
  localparam int DIRECTED_STEPS = 23;
  // A word passes through the input register and, if it makes a row, the output
  // register, so this drain leaves time for non-emitting words to finish too.
  localparam int DRAIN_CYCLES   = 4;
  localparam int TAIL_CYCLES    = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int TIMEOUT_NS     = 5_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic sink_ready = 1'b0;

  ptrd_word_if in_word ();
  ptrd_row_if  out_row ();

  assign out_row.ready = sink_ready;

  planar_tile_row_decoder_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_word     (in_word),
    .out_row     (out_row)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Shadow copy of the decoder: mode, word counter and the stored planes of each line.
  mode_e               shadow_mode;
  pos_t                shadow_pos;
  logic [3*WORD_W-1:0] shadow_planes [SPRITE_LINES];

  // Rows still owed by the block, oldest first.
  row_expect_t pending_rows [$];

  int source_idle_pct;
  int sink_idle_pct;
  int mismatches;
  int rows_seen;
  int words_sent;
  int mode_writes;

  plan_step_t directed_plan [DIRECTED_STEPS];

  // Interleaves four plane words of the given width into 4-bit pixels. The leftmost
  // pixel is the most significant bit of each plane and lands in the lowest nibble.
  function automatic row_t pack_pixels(input word_t p0, input word_t p1, input word_t p2,
                                       input word_t p3, input int width);
    row_t row;
    row = '0;
    for (int n = 0; n < width; n++) begin
      row[PIX_W*n +: PIX_W] = {p3[width-1-n], p2[width-1-n], p1[width-1-n], p0[width-1-n]};
    end
    return row;
  endfunction

  // Advances the shadow by one accepted word. Returns 1 when the word completes a
  // row, which is then handed back through row.
  function automatic logic decode_word(input word_t w, output row_expect_t row);
    row_num_t            line;
    logic [1:0]          plane;
    logic [3*WORD_W-1:0] entry;
    row = '0;
    decode_word = 1'b0;
    if (shadow_mode == MODE_SPRITE) begin
      // Sixty-four words: sixteen lines of plane 0, then planes 1, 2 and 3.
      plane = shadow_pos[5:4];
      line = shadow_pos[3:0];
      shadow_pos = shadow_pos + pos_t'(1);
      if (plane != 2'd3) begin
        shadow_planes[line][WORD_W*plane +: WORD_W] = w;
      end else begin
        entry = shadow_planes[line];
        row.pixels = pack_pixels(entry[15:0], entry[31:16], entry[47:32], w, ROW_PIX);
        row.number = line;
        row.last = (line == SPRITE_LAST);
        decode_word = 1'b1;
      end
    end else begin
      // Sixteen words: the first eight hold planes 0 and 1 as high and low byte,
      // the last eight hold planes 2 and 3 and each one finishes its line.
      line = {1'b0, shadow_pos[2:0]};
      entry = shadow_planes[line];
      if (!shadow_pos[3]) begin
        shadow_planes[line] = {16'h0000, 8'h00, w[7:0], 8'h00, w[15:8]};
      end else begin
        row.pixels = pack_pixels({8'h00, entry[7:0]}, {8'h00, entry[23:16]},
                                 {8'h00, w[15:8]}, {8'h00, w[7:0]}, BYTE_W);
        row.number = line;
        row.last = (line == TILE_LAST);
        decode_word = 1'b1;
      end
      shadow_pos = {2'b00, shadow_pos[3:0] + 4'd1};
    end
  endfunction

  function automatic plan_step_t word_step(input word_t d);
    return '{STEP_WORD, d, 1'b0, '0};
  endfunction

  function automatic plan_step_t checked_step(input word_t d, input row_t pix,
                                              input row_num_t num, input logic last);
    plan_step_t s;
    s = '{STEP_WORD, d, 1'b1, '0};
    s.row.pixels = pix;
    s.row.number = num;
    s.row.last = last;
    return s;
  endfunction

  function automatic plan_step_t mode_step(input mode_e m);
    return '{STEP_MODE, word_t'(m), 1'b0, '0};
  endfunction

  // Random words lean on the corners: all zero, all one and single set bits.
  function automatic word_t next_graphics_word();
    unique case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
      default: return word_t'($urandom());
    endcase
  endfunction

  // Counts a failure and prints the first few of them.
  task automatic report_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Writes the mode register. The block restarts its word count on every write,
  // even of the same value, and so does the shadow.
  task automatic write_mode(input mode_e m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_mode = m;
    shadow_pos = '0;
    mode_writes++;
  endtask

  // Offers one graphics word request, with random idle cycles ahead of it, and
  // waits until the block takes it. Valid stays high into the next request when
  // no idle cycle follows, so it is never lowered and raised in one step.
  task automatic send_word(input word_t w, input logic typed, input row_expect_t typed_row);
    row_expect_t predicted;
    while ($urandom_range(0, 99) < source_idle_pct) begin
      in_word.valid <= 1'b0;
      @(posedge clk);
    end
    in_word.valid <= 1'b1;
    in_word.graphics_word <= w;
    do @(posedge clk); while (!in_word.ready);
    words_sent++;
    if (decode_word(w, predicted)) begin
      pending_rows.push_back(typed ? typed_row : predicted);
    end
  endtask

  // Lets the block run dry: every owed row has come out, and words that make no
  // row have had time to leave the pipeline before the mode is touched.
  task automatic wait_idle();
    in_word.valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Row receiver: checks every accepted row request against the oldest owed row,
  // then decides whether to stall in the next cycle.
  always @(posedge clk) begin : row_monitor
    row_expect_t oldest;
    if (rst_n && out_row.valid && out_row.ready) begin
      rows_seen++;
      if (pending_rows.size() == 0) begin
        report_error($sformatf("row %0d arrived with none owed: pix=%h last=%b",
                               out_row.row_number, out_row.row_pixels, out_row.last_row));
      end else begin
        oldest = pending_rows.pop_front();
        if (out_row.row_pixels !== oldest.pixels || out_row.row_number !== oldest.number ||
            out_row.last_row !== oldest.last) begin
          report_error($sformatf("expected pix=%h num=%0d last=%b, got pix=%h num=%0d last=%b",
                                 oldest.pixels, oldest.number, oldest.last,
                                 out_row.row_pixels, out_row.row_number, out_row.last_row));
        end
      end
    end
    sink_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  initial begin : stimulus
    row_expect_t no_row;
    int          length;
    mode_e       phase_mode;
    no_row = '0;
    in_word.valid <= 1'b0;
    in_word.graphics_word <= '0;
    shadow_mode = MODE_SPRITE;
    shadow_pos = '0;
    mismatches = 0;
    rows_seen = 0;
    words_sent = 0;
    mode_writes = 0;
    source_idle_pct = 17;
    sink_idle_pct = 69;

    // Directed tile: the line contents are chosen so that most rows can be written
    // down by hand. Line 0 is all ones, line 1 all zeros, line 2 only the leftmost
    // pixel of plane 0, line 3 only the rightmost pixel of plane 1, line 4 plane 0
    // alone and line 5 planes 1 and 3. Lines 6 and 7 carry mixed patterns and are
    // left to the shadow, line 7 closing the tile. The word after the tile wraps the
    // counter, then a rewrite of the same mode restarts it mid-tile and the block
    // falls back to sprite mode with a partial sprite.
    directed_plan = '{
      mode_step(MODE_TILE),
      word_step(16'hFFFF),
      word_step(16'h0000),
      word_step(16'h8000),
      word_step(16'h0001),
      word_step(16'hFF00),
      word_step(16'h00FF),
      word_step(16'hA55A),
      word_step(16'h1234),
      checked_step(16'hFFFF, 64'h0000_0000_FFFF_FFFF, row_num_t'(0), 1'b0),
      checked_step(16'h0000, 64'h0000_0000_0000_0000, row_num_t'(1), 1'b0),
      checked_step(16'h0000, 64'h0000_0000_0000_0001, row_num_t'(2), 1'b0),
      checked_step(16'h0000, 64'h0000_0000_2000_0000, row_num_t'(3), 1'b0),
      checked_step(16'h0000, 64'h0000_0000_1111_1111, row_num_t'(4), 1'b0),
      checked_step(16'h00FF, 64'h0000_0000_AAAA_AAAA, row_num_t'(5), 1'b0),
      word_step(16'h1357),
      word_step(16'hFFFF),
      word_step(16'hFFFF),
      word_step(16'h8001),
      mode_step(MODE_TILE),
      mode_step(MODE_SPRITE),
      word_step(16'h0000),
      word_step(16'hFFFF)
    };

    // Synchronous reset, held for a few edges and released once.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == STEP_MODE) begin
        wait_idle();
        write_mode(mode_e'(directed_plan[i].data[0]));
      end else begin
        send_word(directed_plan[i].data, directed_plan[i].typed, directed_plan[i].row);
      end
    end

    // Random part in three stretches: a mostly stalled receiver, a mostly idle
    // sender, then full rate. Each stretch runs a sprite phase, a tile phase and one
    // of either. Phases are mostly whole sprites or tiles; about one in four ends
    // with a broken unit that the next mode write cuts short.
    for (int regime = 0; regime < 3; regime++) begin
      unique case (regime)
        0: begin
          source_idle_pct = 17;
          sink_idle_pct = 69;
        end
        1: begin
          source_idle_pct = 69;
          sink_idle_pct = 17;
        end
        default: begin
          source_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int phase = 0; phase < 3; phase++) begin
        wait_idle();
        if (phase == 0) begin
          phase_mode = MODE_SPRITE;
        end else if (phase == 1) begin
          phase_mode = MODE_TILE;
        end else begin
          phase_mode = mode_e'($urandom_range(0, 1));
        end
        write_mode(phase_mode);
        if (phase_mode == MODE_SPRITE) begin
          length = 4 * WORD_W;
          if ($urandom_range(0, 3) == 0) length += $urandom_range(1, 4 * WORD_W - 1);
        end else begin
          length = WORD_W * $urandom_range(4, 5);
          if ($urandom_range(0, 3) == 0) length += $urandom_range(1, WORD_W - 1);
        end
        repeat (length) send_word(next_graphics_word(), 1'b0, no_row);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Decoded %0d graphics words into %0d rows across %0d mode writes.",
             words_sent, rows_seen, mode_writes);
    $display("Both layouts ran under receiver stalls, sender gaps and at full rate.");
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: a run that hangs on a handshake ends here.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
